@@ design/ueb_pkg.sv @@
// ueb_pkg: shared types, constants and register codes for the brake guard
// no dependencies; used by every design file of the block

package ueb_pkg;

  localparam int SENSOR_COUNT = 10;
  localparam int SIDX_W       = 4;
  localparam int DIST_W       = 16;
  localparam int SPEED_W      = 16;
  localparam int TS_W         = 32;
  localparam int FRAC_W       = 13;
  localparam int ZONE_W       = 4;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 5;
  localparam int PROD_W       = SPEED_W + FRAC_W;

  // sensor layout: front 0..4, side left 5, side right 6, rear 7..9
  localparam int FRONT_FIRST = 0;
  localparam int FRONT_LAST  = 4;
  localparam int LEFT_IDX    = 5;
  localparam int RIGHT_IDX   = 6;
  localparam int REAR_FIRST  = 7;
  localparam int REAR_LAST   = 9;

  // Q4.8 fraction limit, 10.0
  localparam logic signed [FRAC_W-1:0] FRAC_MAX = 13'sd2560;

  localparam logic [DIST_W-1:0] DIST_NONE = '1;

  localparam logic [DIST_W-1:0]  RST_FRONT_THR = 16'd500;
  localparam logic [DIST_W-1:0]  RST_REAR_THR  = 16'd500;
  localparam logic [DIST_W-1:0]  RST_LEFT_THR  = 16'd100;
  localparam logic [DIST_W-1:0]  RST_RIGHT_THR = 16'd100;
  localparam logic [ZONE_W-1:0]  RST_ZONE_EN   = 4'd3;
  localparam logic               RST_HOLD      = 1'b1;
  localparam logic               RST_REPORT    = 1'b0;
  localparam logic [FRAC_W-1:0]  RST_FRAC      = '0;

  typedef enum logic [1:0] {
    MODE_READING = 2'd0,
    MODE_SPEED   = 2'd1,
    MODE_COMMAND = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ZONE_FRONT = 2'd0,
    ZONE_REAR  = 2'd1,
    ZONE_LEFT  = 2'd2,
    ZONE_RIGHT = 2'd3
  } zone_t;

  typedef enum logic [2:0] {
    REG_FRONT_THR  = 3'd0,
    REG_REAR_THR   = 3'd1,
    REG_LEFT_THR   = 3'd2,
    REG_RIGHT_THR  = 3'd3,
    REG_ZONE_EN    = 3'd4,
    REG_HOLD       = 3'd5,
    REG_REPORT_EN  = 3'd6,
    REG_BRAKE_FRAC = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [DIST_W-1:0]        front_thr;
    logic [DIST_W-1:0]        rear_thr;
    logic [DIST_W-1:0]        left_thr;
    logic [DIST_W-1:0]        right_thr;
    logic [ZONE_W-1:0]        zone_en;
    logic                     hold;
    logic                     report_en;
    logic signed [FRAC_W-1:0] brake_frac;
  } ueb_cfg_t;

  typedef struct packed {
    logic [1:0]                mode;
    logic [SIDX_W-1:0]         sensor_index;
    logic [DIST_W-1:0]         distance;
    logic signed [SPEED_W-1:0] speed_value;
    logic [TS_W-1:0]           timestamp;
  } ueb_item_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed_out;
    logic [TS_W-1:0]           timestamp_out;
    logic                      hazard_on;
    logic                      estop_flag;
  } ueb_result_t;

  // zone that watches a given sensor position
  function automatic zone_t sensor_zone(input int idx);
    zone_t z;
    if (idx <= FRONT_LAST) begin
      z = ZONE_FRONT;
    end else if (idx == LEFT_IDX) begin
      z = ZONE_LEFT;
    end else if (idx == RIGHT_IDX) begin
      z = ZONE_RIGHT;
    end else begin
      z = ZONE_REAR;
    end
    return z;
  endfunction

endpackage

@@ design/ueb_chan_if.sv @@
// ueb_chan_if: valid/ready channel interfaces for requests and results
// depends on ueb_pkg for field widths

interface ueb_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         mode;
  logic [ueb_pkg::SIDX_W-1:0]         sensor_index;
  logic [ueb_pkg::DIST_W-1:0]         distance;
  logic signed [ueb_pkg::SPEED_W-1:0] speed_value;
  logic [ueb_pkg::TS_W-1:0]           timestamp;

  modport source (output valid, mode, sensor_index, distance, speed_value, timestamp,
                  input ready);
  modport sink   (input valid, mode, sensor_index, distance, speed_value, timestamp,
                  output ready);
endinterface

interface ueb_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ueb_pkg::SPEED_W-1:0] speed_out;
  logic [ueb_pkg::TS_W-1:0]           timestamp_out;
  logic                               hazard_on;
  logic                               estop_flag;

  modport source (output valid, speed_out, timestamp_out, hazard_on, estop_flag,
                  input ready);
  modport sink   (input valid, speed_out, timestamp_out, hazard_on, estop_flag,
                  output ready);
endinterface

@@ design/ueb_cfg_regs.sv @@
// ueb_cfg_regs: apb-style register file for thresholds, zone enables, hold, report enable and brake fraction
// depends on ueb_pkg

module ueb_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ueb_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [ueb_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ueb_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output ueb_pkg::ueb_cfg_t               cfg
);
  import ueb_pkg::*;

  ueb_cfg_t cfg_r, cfg_nxt;
  logic     wr_en;
  cfg_reg_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_FRONT_THR:  cfg_nxt.front_thr  = pwdata[DIST_W-1:0];
        REG_REAR_THR:   cfg_nxt.rear_thr   = pwdata[DIST_W-1:0];
        REG_LEFT_THR:   cfg_nxt.left_thr   = pwdata[DIST_W-1:0];
        REG_RIGHT_THR:  cfg_nxt.right_thr  = pwdata[DIST_W-1:0];
        REG_ZONE_EN:    cfg_nxt.zone_en    = pwdata[ZONE_W-1:0];
        REG_HOLD:       cfg_nxt.hold       = pwdata[0];
        REG_REPORT_EN:  cfg_nxt.report_en  = pwdata[0];
        REG_BRAKE_FRAC: cfg_nxt.brake_frac = $signed(pwdata[FRAC_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.front_thr  <= RST_FRONT_THR;
      cfg_r.rear_thr   <= RST_REAR_THR;
      cfg_r.left_thr   <= RST_LEFT_THR;
      cfg_r.right_thr  <= RST_RIGHT_THR;
      cfg_r.zone_en    <= RST_ZONE_EN;
      cfg_r.hold       <= RST_HOLD;
      cfg_r.report_en  <= RST_REPORT;
      cfg_r.brake_frac <= RST_FRAC;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_FRONT_THR:  prdata = CFG_DATA_W'(cfg_r.front_thr);
      REG_REAR_THR:   prdata = CFG_DATA_W'(cfg_r.rear_thr);
      REG_LEFT_THR:   prdata = CFG_DATA_W'(cfg_r.left_thr);
      REG_RIGHT_THR:  prdata = CFG_DATA_W'(cfg_r.right_thr);
      REG_ZONE_EN:    prdata = CFG_DATA_W'(cfg_r.zone_en);
      REG_HOLD:       prdata = CFG_DATA_W'(cfg_r.hold);
      REG_REPORT_EN:  prdata = CFG_DATA_W'(cfg_r.report_en);
      REG_BRAKE_FRAC: prdata = CFG_DATA_W'($unsigned(cfg_r.brake_frac));
      default:        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ design/ueb_guard_core.sv @@
// ueb_guard_core: distance store, measured speed, obstacle latch and brake decision
// depends on ueb_pkg; state advances once per item handed over by the top level

module ueb_guard_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ueb_pkg::ueb_cfg_t        cfg,
  input  logic                     step,
  input  ueb_pkg::ueb_item_t       item,
  output logic                     res_valid,
  output ueb_pkg::ueb_result_t     res
);
  import ueb_pkg::*;

  logic [DIST_W-1:0]         dist_r [SENSOR_COUNT];
  logic signed [SPEED_W-1:0] meas_r;
  logic                      latch_r;

  logic [SENSOR_COUNT-1:0]   hit;
  logic                      stop;
  logic                      frac_ok;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-9:0]  prod_q;
  logic signed [PROD_W-8:0]  neg;
  logic signed [SPEED_W-1:0] brake;
  logic                      use_brake;

  // per-sensor compare against its zone threshold, gated by zone enable
  always_comb begin
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      case (sensor_zone(i))
        ZONE_FRONT: hit[i] = cfg.zone_en[ZONE_FRONT] && (dist_r[i] < cfg.front_thr);
        ZONE_REAR:  hit[i] = cfg.zone_en[ZONE_REAR]  && (dist_r[i] < cfg.rear_thr);
        ZONE_LEFT:  hit[i] = cfg.zone_en[ZONE_LEFT]  && (dist_r[i] < cfg.left_thr);
        ZONE_RIGHT: hit[i] = cfg.zone_en[ZONE_RIGHT] && (dist_r[i] < cfg.right_thr);
        default:    hit[i] = 1'b0;
      endcase
    end
  end

  assign stop = |hit;

  // q8.8 times q4.8, floor shift back to q8.8, negate and saturate
  assign frac_ok = !cfg.brake_frac[FRAC_W-1] && (cfg.brake_frac <= FRAC_MAX);
  assign prod    = $signed(PROD_W'(meas_r)) * $signed(PROD_W'(cfg.brake_frac));
  assign prod_q  = prod[PROD_W-1:8];
  assign neg     = -$signed({prod_q[PROD_W-9], prod_q});

  always_comb begin
    if (!frac_ok) begin
      brake = '0;
    end else if (!neg[PROD_W-8] && (neg[PROD_W-9:SPEED_W-1] != '0)) begin
      brake = {1'b0, {(SPEED_W-1){1'b1}}};
    end else if (neg[PROD_W-8] && (neg[PROD_W-9:SPEED_W-1] != '1)) begin
      brake = {1'b1, {(SPEED_W-1){1'b0}}};
    end else begin
      brake = neg[SPEED_W-1:0];
    end
  end

  assign use_brake = stop || (cfg.hold && latch_r);
  assign res_valid = (item.mode == MODE_COMMAND);

  always_comb begin
    res.speed_out     = use_brake ? brake : item.speed_value;
    res.timestamp_out = item.timestamp;
    res.hazard_on     = latch_r || stop;
    res.estop_flag    = stop && cfg.report_en;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        dist_r[i] <= DIST_NONE;
      end
      meas_r  <= '0;
      latch_r <= 1'b0;
    end else if (step) begin
      case (item.mode)
        MODE_READING: begin
          for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (item.sensor_index == SIDX_W'(i)) begin
              dist_r[i] <= item.distance;
            end
          end
        end
        MODE_SPEED:   meas_r <= item.speed_value;
        MODE_COMMAND: latch_r <= latch_r || stop;
        default: ;
      endcase
    end
  end

endmodule

@@ design/ultrasonic_emergency_brake_guard.sv @@
// ultrasonic_emergency_brake_guard: top level with request register and result register
// depends on ueb_pkg, ueb_chan_if, ueb_cfg_regs and ueb_guard_core

// Collision guard between a speed command and the drive. Each request is an
// ultrasonic reading (mode 0, stored per sensor), a measured speed (mode 1) or
// a speed command (mode 2); only commands give a result. A command is passed
// through unless an enabled zone sees a stored distance below its threshold,
// or hold mode is on and the obstacle latch is set; then it is replaced by
// minus measured speed times brake_fraction (Q8.8 x Q4.8, floored, saturated),
// or zero when the fraction is outside 0.0..10.0. Timing: one request per
// clock sustained while results are taken; a command result is offered once
// its request has passed the request register and then the compare/multiply
// stage into the result register. Readings and speeds take effect on the
// next request, so any mix may be streamed back to back.
// Registers sit at byte address 4*index and must only be written while no
// request is in flight. No clearing pass is needed after reset.

module ultrasonic_emergency_brake_guard (
  input  logic                            clk,
  input  logic                            rst_n,
  ueb_in_if.sink                          in_chan,
  ueb_out_if.source                       out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ueb_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [ueb_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ueb_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import ueb_pkg::*;

  ueb_cfg_t    cfg;

  // request register
  logic        req_valid_r, req_valid_nxt;
  ueb_item_t   req_item_r;
  ueb_item_t   in_item;

  // result register
  logic        out_valid_r, out_valid_nxt;
  ueb_result_t out_res_r;

  logic        core_res_valid;
  ueb_result_t core_res;
  logic        advance;
  logic        in_take;

  ueb_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ueb_guard_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (advance),
    .item      (req_item_r),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  always_comb begin
    in_item.mode         = in_chan.mode;
    in_item.sensor_index = in_chan.sensor_index;
    in_item.distance     = in_chan.distance;
    in_item.speed_value  = in_chan.speed_value;
    in_item.timestamp    = in_chan.timestamp;
  end

  // the held request moves on when it makes no result or the result slot is free
  assign advance = req_valid_r && (!core_res_valid || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !req_valid_r || advance;
  assign in_take = in_chan.valid && in_chan.ready;

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (in_take) begin
      req_valid_nxt = 1'b1;
    end else if (advance) begin
      req_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && core_res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_item_r <= in_item;
    end
    if (advance && core_res_valid) begin
      out_res_r <= core_res;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.speed_out     = out_res_r.speed_out;
  assign out_chan.timestamp_out = out_res_r.timestamp_out;
  assign out_chan.hazard_on     = out_res_r.hazard_on;
  assign out_chan.estop_flag    = out_res_r.estop_flag;

endmodule

@@ design/ueb_checker.sv @@
// ueb_checker: port-level assertions on the result channel of the brake guard
// depends on ueb_pkg and ueb_chan_if; bound to the top level below

module ueb_checker (
  input logic         clk,
  input logic         rst_n,
  ueb_out_if.source   out_chan
);
  import ueb_pkg::*;

  logic seen_hazard_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_hazard_r <= 1'b0;
    end else if (out_chan.valid && out_chan.ready && out_chan.hazard_on) begin
      seen_hazard_r <= 1'b1;
    end
  end

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |=> out_chan.valid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |=>
      $stable(out_chan.speed_out) && $stable(out_chan.timestamp_out) &&
      $stable(out_chan.hazard_on) && $stable(out_chan.estop_flag))
    else $error("result payload changed while stalled");

  a_hazard_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && seen_hazard_r |-> out_chan.hazard_on)
    else $error("hazard light cleared without reset");

  a_stop_sets_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.estop_flag |-> out_chan.hazard_on)
    else $error("emergency stop without hazard light");

endmodule

bind ultrasonic_emergency_brake_guard ueb_checker u_ueb_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_chan (out_chan)
);

@@ tb/tb_ultrasonic_emergency_brake_guard.sv @@
`timescale 1ns / 1ps
// tb_ultrasonic_emergency_brake_guard: self-checking bench for the collision brake guard
// needs ueb_pkg, ueb_chan_if and the guard rtl; predicts drive results on its own or takes them from the directed table

module tb_ultrasonic_emergency_brake_guard;
  import ueb_pkg::*;

  // mode 3 has no name in the package, it is pure noise for the block
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam bit TYPED   = 1'b1;
  localparam bit PREDICT = 1'b0;

  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 145;
  localparam int CALM_ITEMS      = 40;
  localparam int PRESSURE_PHASE  = 1;
  localparam int PRESSURE_AT     = 60;
  localparam int PRESSURE_BURST  = 40;
  localparam int HOLD_OFF_CYCLES = 150;
  // margin for readings still in flight
  localparam int DRAIN_CYCLES    = 6;
  localparam int REPORT_LIMIT    = 10;
  localparam int CYCLE_LIMIT     = 500000;

  typedef struct {
    ueb_item_t   req;
    bit          typed;
    ueb_result_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  ueb_in_if  in_bus ();
  ueb_out_if out_bus ();

  ultrasonic_emergency_brake_guard dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // shadow of the guard: settings, stored distances, measured speed, latch
  ueb_cfg_t                  guard_cfg;
  logic [DIST_W-1:0]         dist_mm [SENSOR_COUNT];
  logic signed [SPEED_W-1:0] meas_spd;
  bit                        latch_set;

  ueb_result_t expected_drive [$];
  stim_row_t   directed_rows [$];
  ueb_result_t want;
  int          mismatches;
  int          cycle_count;

  // coordination between the request side and the result side
  bit calm;
  bit rx_hold_req;
  bit rx_holding;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // drive prediction
  // ---------------------------------------------------------------------------

  // any enabled zone with a stored distance strictly below its limit
  function automatic bit obstacle_seen();
    bit hit;
    hit = 1'b0;
    for (int i = FRONT_FIRST; i <= FRONT_LAST; i++)
      if (guard_cfg.zone_en[ZONE_FRONT] && dist_mm[i] < guard_cfg.front_thr) hit = 1'b1;
    for (int i = REAR_FIRST; i <= REAR_LAST; i++)
      if (guard_cfg.zone_en[ZONE_REAR] && dist_mm[i] < guard_cfg.rear_thr) hit = 1'b1;
    if (guard_cfg.zone_en[ZONE_LEFT] && dist_mm[LEFT_IDX] < guard_cfg.left_thr) hit = 1'b1;
    if (guard_cfg.zone_en[ZONE_RIGHT] && dist_mm[RIGHT_IDX] < guard_cfg.right_thr) hit = 1'b1;
    return hit;
  endfunction

  // minus speed times fraction: Q8.8 x Q4.8, floor back to Q8.8, saturate
  function automatic logic signed [SPEED_W-1:0] brake_drive();
    longint frac;
    longint prod;
    longint neg;
    frac = longint'(signed'(guard_cfg.brake_frac));
    // fraction outside 0.0 .. 10.0 means no reverse drive at all
    if (frac < 0 || frac > longint'(FRAC_MAX)) return '0;
    prod = longint'(meas_spd) * frac;
    neg  = -(prod >>> 8);
    if (neg > 32767) neg = 32767;
    if (neg < -32768) neg = -32768;
    return neg[SPEED_W-1:0];
  endfunction

  // apply one request to the shadow state; returns 1 when a drive result follows
  function automatic bit predict_drive(input ueb_item_t req, output ueb_result_t drive);
    bit hit;
    drive = '0;
    if (req.mode == MODE_READING) begin
      // readings from sensor positions past the last one are dropped
      if (req.sensor_index < SENSOR_COUNT) dist_mm[req.sensor_index] = req.distance;
      return 1'b0;
    end
    if (req.mode == MODE_SPEED) begin
      meas_spd = req.speed_value;
      return 1'b0;
    end
    if (req.mode != MODE_COMMAND) return 1'b0;
    hit = obstacle_seen();
    if (hit) latch_set = 1'b1;
    drive.speed_out     = (hit || (guard_cfg.hold && latch_set)) ? brake_drive()
                                                                 : req.speed_value;
    drive.timestamp_out = req.timestamp;
    drive.hazard_on     = latch_set;
    drive.estop_flag    = hit && guard_cfg.report_en;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int zone_limit(input int idx);
    if (idx <= FRONT_LAST) return int'(guard_cfg.front_thr);
    if (idx == LEFT_IDX) return int'(guard_cfg.left_thr);
    if (idx == RIGHT_IDX) return int'(guard_cfg.right_thr);
    return int'(guard_cfg.rear_thr);
  endfunction

  // distances cluster around the current limit so that zones flip often
  function automatic logic [DIST_W-1:0] pick_distance(input int idx);
    int lim;
    int d;
    lim = zone_limit(idx);
    case ($urandom_range(0, 9))
      0:       d = 0;
      1:       d = 65535;
      2, 3:    d = $urandom_range(0, 65535);
      4, 5, 6: d = lim - 2 + $urandom_range(0, 4);
      default: d = lim + $urandom_range(0, 4000);
    endcase
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    return d[DIST_W-1:0];
  endfunction

  function automatic logic signed [SPEED_W-1:0] pick_speed();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly well-formed requests, some noise; counted is 0 for ignored ones
  function automatic ueb_item_t random_request(output bit counted);
    ueb_item_t req;
    int        r;
    req.mode         = MODE_COMMAND;
    req.sensor_index = 4'($urandom);
    req.distance     = 16'($urandom);
    req.speed_value  = pick_speed();
    req.timestamp    = $urandom;
    counted          = 1'b1;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      req.mode = MODE_UNUSED;
      counted  = 1'b0;
    end else if (r < 12) begin
      req.mode         = MODE_READING;
      req.sensor_index = 4'($urandom_range(SENSOR_COUNT, 15));
      counted          = 1'b0;
    end else if (r < 42) begin
      req.mode         = MODE_READING;
      req.sensor_index = 4'($urandom_range(0, SENSOR_COUNT - 1));
      req.distance     = pick_distance(int'(req.sensor_index));
    end else if (r < 57) begin
      req.mode = MODE_SPEED;
    end
    return req;
  endfunction

  // mostly back to back, sometimes a short pause, rarely a long one
  function automatic int idle_gap();
    int gap;
    gap = 0;
    if (!calm) begin
      case ($urandom_range(0, 19))
        0:             gap = $urandom_range(8, 30);
        1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
        default:       gap = 0;
      endcase
    end
    return gap;
  endfunction

  function automatic ueb_cfg_t phase_setting(input int p);
    ueb_cfg_t c;
    c.front_thr  = 16'($urandom);
    c.rear_thr   = 16'($urandom);
    c.left_thr   = 16'($urandom_range(0, 2000));
    c.right_thr  = 16'($urandom_range(0, 2000));
    c.zone_en    = 4'($urandom);
    c.hold       = 1'($urandom);
    c.report_en  = 1'($urandom);
    c.brake_frac = 13'($urandom_range(0, 2560));
    case (p)
      0: begin
        c.front_thr = 16'd500;  c.rear_thr = 16'd500;
        c.left_thr = 16'd100;   c.right_thr = 16'd100;
        c.zone_en = 4'hf;  c.hold = 1'b0;  c.report_en = 1'b1;  c.brake_frac = 13'sd256;
      end
      1: begin
        c.front_thr = 16'd2000; c.rear_thr = 16'd2000;
        c.left_thr = 16'd300;   c.right_thr = 16'd300;
        c.zone_en = 4'hf;  c.hold = 1'b1;  c.report_en = 1'b1;  c.brake_frac = 13'sd2560;
      end
      2: begin
        // zero limits: nothing can ever be below them
        c.front_thr = '0;  c.rear_thr = '0;  c.left_thr = '0;  c.right_thr = '0;
        c.zone_en = 4'hf;  c.hold = 1'b0;  c.report_en = 1'b1;  c.brake_frac = 13'sd2561;
      end
      3: begin
        c.front_thr = '1;  c.rear_thr = '1;  c.left_thr = '1;  c.right_thr = '1;
        c.zone_en = 4'h0;  c.hold = 1'b0;  c.report_en = 1'b0;  c.brake_frac = -13'sd4096;
      end
      4: begin
        c.front_thr = '1;  c.rear_thr = '1;  c.left_thr = '1;  c.right_thr = '1;
        c.zone_en = 4'hf;  c.hold = 1'b1;  c.report_en = 1'b1;  c.brake_frac = 13'sd4095;
      end
      5: begin
        c.zone_en = 4'b0101;  c.hold = 1'b0;  c.report_en = 1'b1;  c.brake_frac = -13'sd1;
      end
      default: ;
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration port: setup cycle, then access cycle; the shadow follows
  // ---------------------------------------------------------------------------

  task automatic reg_write(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      REG_FRONT_THR:  guard_cfg.front_thr  = v[DIST_W-1:0];
      REG_REAR_THR:   guard_cfg.rear_thr   = v[DIST_W-1:0];
      REG_LEFT_THR:   guard_cfg.left_thr   = v[DIST_W-1:0];
      REG_RIGHT_THR:  guard_cfg.right_thr  = v[DIST_W-1:0];
      REG_ZONE_EN:    guard_cfg.zone_en    = v[ZONE_W-1:0];
      REG_HOLD:       guard_cfg.hold       = v[0];
      REG_REPORT_EN:  guard_cfg.report_en  = v[0];
      REG_BRAKE_FRAC: guard_cfg.brake_frac = v[FRAC_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setting(input ueb_cfg_t c);
    reg_write(REG_FRONT_THR, 32'(c.front_thr));
    reg_write(REG_REAR_THR, 32'(c.rear_thr));
    reg_write(REG_LEFT_THR, 32'(c.left_thr));
    reg_write(REG_RIGHT_THR, 32'(c.right_thr));
    reg_write(REG_ZONE_EN, 32'(c.zone_en));
    reg_write(REG_HOLD, 32'(c.hold));
    reg_write(REG_REPORT_EN, 32'(c.report_en));
    reg_write(REG_BRAKE_FRAC, {{(CFG_DATA_W - FRAC_W){c.brake_frac[FRAC_W-1]}}, c.brake_frac});
  endtask

  // ---------------------------------------------------------------------------
  // request side: valid stays up from one request to the next unless a gap
  // is taken; prediction happens at the edge where the request is taken
  // ---------------------------------------------------------------------------

  task automatic send_request(input ueb_item_t req, input bit typed,
                              input ueb_result_t typed_res);
    int          gap;
    ueb_result_t drive;
    gap = idle_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.mode         <= req.mode;
    in_bus.sensor_index <= req.sensor_index;
    in_bus.distance     <= req.distance;
    in_bus.speed_value  <= req.speed_value;
    in_bus.timestamp    <= req.timestamp;
    do @(posedge clk); while (!in_bus.ready);
    if (predict_drive(req, drive)) expected_drive.push_back(typed ? typed_res : drive);
  endtask

  task automatic add_row(input logic [1:0] mode, input int idx, input int dist_val,
                         input logic signed [SPEED_W-1:0] spd, input logic [TS_W-1:0] ts,
                         input bit typed, input logic signed [SPEED_W-1:0] want_spd,
                         input bit want_hz, input bit want_es);
    stim_row_t row;
    row.req.mode              = mode;
    row.req.sensor_index      = idx[SIDX_W-1:0];
    row.req.distance          = dist_val[DIST_W-1:0];
    row.req.speed_value       = spd;
    row.req.timestamp         = ts;
    row.typed                 = typed;
    row.want.speed_out        = want_spd;
    row.want.timestamp_out    = ts;
    row.want.hazard_on        = want_hz;
    row.want.estop_flag       = want_es;
    directed_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure, plus one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int run;
    bit rdy;
    out_bus.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        // long hold-off so the pipeline fills and the input stalls
        rx_holding = 1'b1;
        for (int c = 0; c < HOLD_OFF_CYCLES; c++) begin
          out_bus.ready <= 1'b0;
          @(posedge clk);
        end
        rx_holding  = 1'b0;
        rx_hold_req = 1'b0;
      end else begin
        if (calm) begin
          rdy = 1'b1;
          run = 1;
        end else begin
          case ($urandom_range(0, 19))
            0:          begin rdy = 1'b0; run = $urandom_range(15, 50); end
            1, 2, 3, 4: begin rdy = 1'b0; run = $urandom_range(1, 3);   end
            default:    begin rdy = 1'b1; run = $urandom_range(1, 8);   end
          endcase
        end
        repeat (run) begin
          out_bus.ready <= rdy;
          @(posedge clk);
        end
      end
    end
  end

  // every taken result is held against the oldest waiting expectation
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_drive.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: speed %0d ts %h hazard %b estop %b",
                   out_bus.speed_out, out_bus.timestamp_out, out_bus.hazard_on,
                   out_bus.estop_flag);
      end else begin
        want = expected_drive.pop_front();
        if (out_bus.speed_out !== want.speed_out ||
            out_bus.timestamp_out !== want.timestamp_out ||
            out_bus.hazard_on !== want.hazard_on ||
            out_bus.estop_flag !== want.estop_flag) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("drive mismatch: exp speed %0d ts %h hz %b es %b, got %0d %h %b %b",
                     want.speed_out, want.timestamp_out, want.hazard_on,
                     want.estop_flag, out_bus.speed_out, out_bus.timestamp_out,
                     out_bus.hazard_on, out_bus.estop_flag);
        end
      end
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    ueb_item_t req;
    bit        counted;
    int        sent;

    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.mode         = '0;
    in_bus.sensor_index = '0;
    in_bus.distance     = '0;
    in_bus.speed_value  = '0;
    in_bus.timestamp    = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    calm                = 1'b0;
    rx_hold_req         = 1'b0;
    rx_holding          = 1'b0;
    mismatches          = 0;
    cycle_count         = 0;

    // shadow state after reset
    guard_cfg.front_thr  = RST_FRONT_THR;
    guard_cfg.rear_thr   = RST_REAR_THR;
    guard_cfg.left_thr   = RST_LEFT_THR;
    guard_cfg.right_thr  = RST_RIGHT_THR;
    guard_cfg.zone_en    = RST_ZONE_EN;
    guard_cfg.hold       = RST_HOLD;
    guard_cfg.report_en  = RST_REPORT;
    guard_cfg.brake_frac = RST_FRAC;
    foreach (dist_mm[i]) dist_mm[i] = DIST_NONE;
    meas_spd  = '0;
    latch_set = 1'b0;

    // directed table, run under the reset settings (front/rear enabled,
    // hold on, no reporting, fraction zero so every brake value is zero)
    //      mode          idx mm     speed        timestamp     chk      speed    hz    es
    add_row(MODE_COMMAND, 0,  0,     16'sh7fff,   32'hffffffff, TYPED,   16'sh7fff, 0, 0);
    add_row(MODE_COMMAND, 0,  0,     16'sh8000,   32'h00000000, TYPED,   16'sh8000, 0, 0);
    add_row(MODE_SPEED,   0,  0,     16'sh7fff,   32'h0,        PREDICT, 0,         0, 0);
    // reading from a position past the last sensor is dropped
    add_row(MODE_READING, 15, 0,     0,           32'h0,        PREDICT, 0,         0, 0);
    // unused mode, no effect and no result
    add_row(MODE_UNUSED,  0,  0,     0,           32'h0,        PREDICT, 0,         0, 0);
    add_row(MODE_COMMAND, 0,  0,     16'sd100,    32'h1,        TYPED,   16'sd100,  0, 0);
    // left zone is disabled after reset
    add_row(MODE_READING, 5,  0,     0,           32'h0,        PREDICT, 0,         0, 0);
    add_row(MODE_COMMAND, 0,  0,     -16'sd256,   32'h2,        TYPED,   -16'sd256, 0, 0);
    // rear one below its limit: braked, latch set, no report
    add_row(MODE_READING, 9,  499,   0,           32'h0,        PREDICT, 0,         0, 0);
    add_row(MODE_COMMAND, 0,  0,     16'sd200,    32'h3,        TYPED,   0,         1, 0);
    // distance equal to the limit is clear, hold keeps braking
    add_row(MODE_READING, 9,  500,   0,           32'h0,        PREDICT, 0,         0, 0);
    add_row(MODE_COMMAND, 0,  0,     16'sd300,    32'h4,        TYPED,   0,         1, 0);
    add_row(MODE_READING, 0,  65535, 0,           32'h0,        PREDICT, 0,         0, 0);
    add_row(MODE_READING, 4,  0,     0,           32'h0,        PREDICT, 0,         0, 0);
    add_row(MODE_COMMAND, 0,  0,     -16'sd1,     32'h5,        PREDICT, 0,         0, 0);
    add_row(MODE_READING, 4,  65535, 0,           32'h0,        PREDICT, 0,         0, 0);
    add_row(MODE_READING, 5,  65535, 0,           32'h0,        PREDICT, 0,         0, 0);
    add_row(MODE_READING, 6,  0,     0,           32'h0,        PREDICT, 0,         0, 0);
    add_row(MODE_SPEED,   0,  0,     16'sh8000,   32'h0,        PREDICT, 0,         0, 0);
    add_row(MODE_COMMAND, 0,  0,     16'sh1234,   32'ha5a5a5a5, TYPED,   0,         1, 0);
    add_row(MODE_READING, 6,  65535, 0,           32'h0,        PREDICT, 0,         0, 0);
    add_row(MODE_READING, 9,  65535, 0,           32'h0,        PREDICT, 0,         0, 0);
    add_row(MODE_SPEED,   0,  0,     0,           32'h0,        PREDICT, 0,         0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      // settle: no request in flight before touching the registers
      in_bus.valid <= 1'b0;
      while (expected_drive.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      load_setting(phase_setting(p));

      // odd phases open with a stretch of back-to-back traffic
      calm = p[0];
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if (sent >= CALM_ITEMS) calm = 1'b0;
        if (p == PRESSURE_PHASE && sent == PRESSURE_AT) begin
          // hold the result side off and keep offering commands
          in_bus.valid <= 1'b0;
          calm        = 1'b1;
          rx_hold_req = 1'b1;
          do @(posedge clk); while (!rx_holding);
          repeat (PRESSURE_BURST) begin
            req      = random_request(counted);
            req.mode = MODE_COMMAND;
            send_request(req, PREDICT, '0);
          end
          sent += PRESSURE_BURST;
          calm  = 1'b0;
        end
        req = random_request(counted);
        send_request(req, PREDICT, '0);
        if (counted) sent++;
      end
    end

    in_bus.valid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_drive.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
